### hdl/rlbc_pkg.sv
// ----------------------------------------------------------------------------
// RGB LED blink controller package
// Shared types, codes and the preset color table.
// ----------------------------------------------------------------------------
package rlbc_pkg;

  // Fixed field widths
  localparam int unsigned TIME_W    = 15;
  localparam int unsigned LIMIT_W   = 16;
  localparam int unsigned REPEAT_W  = 15;
  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned COLOR_W   = 3;
  localparam int unsigned LEVEL_W   = 8;

  localparam logic [LEVEL_W-1:0]   LEVEL_FULL  = 8'hFF;
  localparam logic [LEVEL_W-1:0]   LEVEL_DARK  = 8'h00;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 16'hFFFF;
  localparam logic [LIMIT_W-1:0]   LIMIT_ENDLESS = 16'hFFFF;

  // Command codes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_ON    = 2'd1,
    OP_OFF   = 2'd2,
    OP_BLINK = 2'd3
  } op_e;

  // Blink phase, reported as mode
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LIT  = 2'd1,
    PH_DARK = 2'd2
  } phase_e;

  // Preset color codes
  typedef enum logic [COLOR_W-1:0] {
    COL_RED     = 3'd0,
    COL_GREEN   = 3'd1,
    COL_BLUE    = 3'd2,
    COL_YELLOW  = 3'd3,
    COL_CYAN    = 3'd4,
    COL_MAGENTA = 3'd5,
    COL_WHITE   = 3'd6,
    COL_NONE    = 3'd7
  } color_e;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } rgb_t;

  // One command as it travels from the input register to the engine
  typedef struct packed {
    op_e                       op;
    logic [COLOR_W-1:0]        color;
    logic [TIME_W-1:0]         on_time;
    logic [TIME_W-1:0]         off_time;
    logic signed [LIMIT_W-1:0] repeat_limit;
  } item_t;

  typedef struct packed {
    rgb_t        levels;
    logic [1:0]  mode;
  } result_t;

  // Map a preset to levels; the unused code keeps the current levels
  function automatic rgb_t color_levels(logic [COLOR_W-1:0] color, rgb_t cur);
    rgb_t lv;
    lv = cur;
    case (color_e'(color))
      COL_RED:     lv = '{LEVEL_FULL, LEVEL_DARK, LEVEL_DARK};
      COL_GREEN:   lv = '{LEVEL_DARK, LEVEL_FULL, LEVEL_DARK};
      COL_BLUE:    lv = '{LEVEL_DARK, LEVEL_DARK, LEVEL_FULL};
      COL_YELLOW:  lv = '{LEVEL_FULL, LEVEL_FULL, LEVEL_DARK};
      COL_CYAN:    lv = '{LEVEL_DARK, LEVEL_FULL, LEVEL_FULL};
      COL_MAGENTA: lv = '{LEVEL_FULL, LEVEL_DARK, LEVEL_FULL};
      COL_WHITE:   lv = '{LEVEL_FULL, LEVEL_FULL, LEVEL_FULL};
      default:     lv = cur;
    endcase
    return lv;
  endfunction

endpackage

### hdl/rlbc_engine.sv
// ----------------------------------------------------------------------------
// RGB LED blink controller engine
// Holds the blink state and applies one command per step.
// ----------------------------------------------------------------------------
module rlbc_engine #(
  parameter int unsigned DURATION_BITS = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  rlbc_pkg::item_t      item_i,
  output rlbc_pkg::result_t    result_o
);

  localparam int unsigned LenW =
      (DURATION_BITS < rlbc_pkg::TIME_W) ? DURATION_BITS : rlbc_pkg::TIME_W;

  rlbc_pkg::phase_e                          phase_q, phase_d;
  logic [rlbc_pkg::ELAPSED_W-1:0]            elapsed_q, elapsed_d;
  logic [rlbc_pkg::REPEAT_W-1:0]             repeats_q, repeats_d;
  logic [rlbc_pkg::COLOR_W-1:0]              color_q, color_d;
  logic [LenW-1:0]                           lit_q, lit_d;
  logic [LenW-1:0]                           dark_q, dark_d;
  logic signed [rlbc_pkg::LIMIT_W-1:0]       limit_q, limit_d;
  rlbc_pkg::rgb_t                            levels_q, levels_d;

  logic [rlbc_pkg::ELAPSED_W-1:0]            elapsed_inc;
  logic [rlbc_pkg::ELAPSED_W-1:0]            lit_ext, dark_ext;
  logic [rlbc_pkg::REPEAT_W-1:0]             repeats_inc;
  logic                                      again;

  // Saturating tick count and zero-extended phase lengths
  assign elapsed_inc = (elapsed_q != rlbc_pkg::ELAPSED_MAX) ?
                       elapsed_q + 1'b1 : elapsed_q;
  assign lit_ext     = {{(rlbc_pkg::ELAPSED_W-LenW){1'b0}}, lit_q};
  assign dark_ext    = {{(rlbc_pkg::ELAPSED_W-LenW){1'b0}}, dark_q};
  assign repeats_inc = repeats_q + 1'b1;

  // Continue blinking while the repeat count stays below the limit, or always when the limit is endless
  always_comb begin
    if (limit_q == rlbc_pkg::LIMIT_ENDLESS) begin
      again = 1'b1;
    end else begin
      again = $signed({1'b0, repeats_inc}) < limit_q;
    end
  end

  // Apply one command to the state
  always_comb begin
    phase_d   = phase_q;
    elapsed_d = elapsed_q;
    repeats_d = repeats_q;
    color_d   = color_q;
    lit_d     = lit_q;
    dark_d    = dark_q;
    limit_d   = limit_q;
    levels_d  = levels_q;
    case (item_i.op)
      rlbc_pkg::OP_TICK: begin
        if (phase_q == rlbc_pkg::PH_LIT) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= lit_ext) begin
            levels_d  = '0;
            elapsed_d = '0;
            phase_d   = rlbc_pkg::PH_DARK;
          end
        end else if (phase_q == rlbc_pkg::PH_DARK) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc >= dark_ext) begin
            if (limit_q != rlbc_pkg::LIMIT_ENDLESS) begin
              repeats_d = repeats_inc;
            end
            if (again) begin
              levels_d  = rlbc_pkg::color_levels(color_q, levels_q);
              elapsed_d = '0;
              phase_d   = rlbc_pkg::PH_LIT;
            end else begin
              phase_d = rlbc_pkg::PH_IDLE;
            end
          end
        end
      end
      rlbc_pkg::OP_ON: begin
        levels_d = rlbc_pkg::color_levels(item_i.color, levels_q);
        phase_d  = rlbc_pkg::PH_IDLE;
      end
      rlbc_pkg::OP_OFF: begin
        levels_d = '0;
        phase_d  = rlbc_pkg::PH_IDLE;
      end
      rlbc_pkg::OP_BLINK: begin
        lit_d     = item_i.on_time[LenW-1:0];
        dark_d    = item_i.off_time[LenW-1:0];
        limit_d   = item_i.repeat_limit;
        repeats_d = '0;
        elapsed_d = '0;
        color_d   = item_i.color;
        levels_d  = rlbc_pkg::color_levels(item_i.color, levels_q);
        phase_d   = rlbc_pkg::PH_LIT;
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  // Advance the state on each step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= rlbc_pkg::PH_IDLE;
      elapsed_q <= '0;
      repeats_q <= '0;
      color_q   <= '0;
      lit_q     <= '0;
      dark_q    <= '0;
      limit_q   <= '0;
      levels_q  <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      elapsed_q <= elapsed_d;
      repeats_q <= repeats_d;
      color_q   <= color_d;
      lit_q     <= lit_d;
      dark_q    <= dark_d;
      limit_q   <= limit_d;
      levels_q  <= levels_d;
    end
  end

  // Result reflects the state after this command
  assign result_o.levels = levels_d;
  assign result_o.mode   = phase_d;

endmodule

### hdl/rgb_led_blink_controller.sv
// ----------------------------------------------------------------------------
// RGB LED blink controller
// Command-driven PWM level generator for an RGB LED with timed blinking.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the in_valid_i/in_ready_o channel: a millisecond tick,
//   on with a preset color, off, or blink with lit and dark lengths in ticks
//   and a repeat limit (-1 blinks forever). Every command gives exactly one
//   result on out_valid_o/out_ready_i: the three PWM levels and the mode
//   (idle, lit phase, dark phase) after that command.
//   A result is registered: its command waits in the input register, and
//   the engine's result is written to the result register when the command
//   leaves it, so a receiver stall can hold the command there.
//   Throughput is one command per cycle while the receiver takes results;
//   the state update is a single compare-and-add pass.
//   When the receiver stalls, the result register holds; an empty input
//   register still takes one command, and in_ready_o stays low while the
//   input register is full until the result is taken.
//   Reset clears the valid flags of both registers and the engine state: mode
//   idle, LED off, all counters and blink settings zero; payloads are not reset.
// ----------------------------------------------------------------------------
module rgb_led_blink_controller #(
  parameter int unsigned DURATION_BITS = 15
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         op_i,
  input  logic [rlbc_pkg::COLOR_W-1:0]       color_i,
  input  logic [rlbc_pkg::TIME_W-1:0]        on_time_i,
  input  logic [rlbc_pkg::TIME_W-1:0]        off_time_i,
  input  logic signed [rlbc_pkg::LIMIT_W-1:0] repeat_limit_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [rlbc_pkg::LEVEL_W-1:0]       red_level_o,
  output logic [rlbc_pkg::LEVEL_W-1:0]       green_level_o,
  output logic [rlbc_pkg::LEVEL_W-1:0]       blue_level_o,
  output logic [1:0]                         mode_o
);

  rlbc_pkg::item_t   item_q;
  logic              in_valid_q;
  rlbc_pkg::result_t result_d;
  rlbc_pkg::result_t result_q;
  logic              out_valid_q;
  logic              in_fire;
  logic              step;

  // Move the held command to the result register when it has room
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;
  assign in_fire    = in_valid_i && in_ready_o;

  // Track occupancy of both registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_fire || (in_valid_q && !step);
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the command payload on each transaction
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.op           <= rlbc_pkg::op_e'(op_i);
      item_q.color        <= color_i;
      item_q.on_time      <= on_time_i;
      item_q.off_time     <= off_time_i;
      item_q.repeat_limit <= repeat_limit_i;
    end
  end

  rlbc_engine #(
    .DURATION_BITS(DURATION_BITS)
  ) u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .item_i  (item_q),
    .result_o(result_d)
  );

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (step) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_level_o   = result_q.levels.red;
  assign green_level_o = result_q.levels.green;
  assign blue_level_o  = result_q.levels.blue;
  assign mode_o        = result_q.mode;

endmodule
